>>> src/mve_pkg.sv
`default_nettype none
package mve_pkg;

   localparam int unsigned QUEUE_DEPTH = 4;

   // one encoded item: up to nine bytes, first byte in the top lane
   localparam int unsigned ITEM_BYTES = 9;
   localparam int unsigned ITEM_W     = 8 * ITEM_BYTES;
   localparam int unsigned COUNT_W    = 4;

   typedef enum logic [3:0] {
      ACT_NIL     = 4'd0,
      ACT_TRUE    = 4'd1,
      ACT_FALSE   = 4'd2,
      ACT_SINT    = 4'd3,
      ACT_UINT    = 4'd4,
      ACT_F32     = 4'd5,
      ACT_F64     = 4'd6,
      ACT_STR     = 4'd7,
      ACT_BIN     = 4'd8,
      ACT_MAP     = 4'd9,
      ACT_ARRAY   = 4'd10,
      ACT_PAYLOAD = 4'd11
   } action_type;

   localparam logic [7:0] TAG_NIL    = 8'hC0;
   localparam logic [7:0] TAG_FALSE  = 8'hC2;
   localparam logic [7:0] TAG_TRUE   = 8'hC3;
   localparam logic [7:0] TAG_BIN8   = 8'hC4;
   localparam logic [7:0] TAG_BIN16  = 8'hC5;
   localparam logic [7:0] TAG_BIN32  = 8'hC6;
   localparam logic [7:0] TAG_F32    = 8'hCA;
   localparam logic [7:0] TAG_F64    = 8'hCB;
   localparam logic [7:0] TAG_U8     = 8'hCC;
   localparam logic [7:0] TAG_U16    = 8'hCD;
   localparam logic [7:0] TAG_U32    = 8'hCE;
   localparam logic [7:0] TAG_U64    = 8'hCF;
   localparam logic [7:0] TAG_I8     = 8'hD0;
   localparam logic [7:0] TAG_I16    = 8'hD1;
   localparam logic [7:0] TAG_I32    = 8'hD2;
   localparam logic [7:0] TAG_I64    = 8'hD3;
   localparam logic [7:0] TAG_STR8   = 8'hD9;
   localparam logic [7:0] TAG_STR16  = 8'hDA;
   localparam logic [7:0] TAG_STR32  = 8'hDB;
   localparam logic [7:0] TAG_ARR16  = 8'hDC;
   localparam logic [7:0] TAG_ARR32  = 8'hDD;
   localparam logic [7:0] TAG_MAP16  = 8'hDE;
   localparam logic [7:0] TAG_MAP32  = 8'hDF;
   localparam logic [7:0] TAG_FIXMAP = 8'h80;
   localparam logic [7:0] TAG_FIXARR = 8'h90;
   localparam logic [7:0] TAG_FIXSTR = 8'hA0;

   typedef struct packed {
      logic [ITEM_W-1:0]  bytes;
      logic [COUNT_W-1:0] count;
   } entry_type;

endpackage
`default_nettype wire

>>> src/mve_front.sv
`default_nettype none
module mve_front (
   input  wire logic [3:0]        action,
   input  wire logic [63:0]       value,
   input  wire logic [31:0]       length,
   input  wire logic [7:0]        payload_byte,
   output logic                   entry_valid,
   output mve_pkg::entry_type     entry
);

   logic [7:0]  tag;
   logic [3:0]  nbytes;
   logic [63:0] data;
   logic [63:0] aligned;
   logic [7:0]  uint_tag;
   logic [3:0]  uint_nbytes;

   // smallest unsigned form, shared by uint and non-negative sint
   always_comb begin
      if (value[63:7] == 57'd0) begin
         uint_tag    = value[7:0];
         uint_nbytes = 4'd0;
      end else if (value[63:8] == 56'd0) begin
         uint_tag    = mve_pkg::TAG_U8;
         uint_nbytes = 4'd1;
      end else if (value[63:16] == 48'd0) begin
         uint_tag    = mve_pkg::TAG_U16;
         uint_nbytes = 4'd2;
      end else if (value[63:32] == 32'd0) begin
         uint_tag    = mve_pkg::TAG_U32;
         uint_nbytes = 4'd4;
      end else begin
         uint_tag    = mve_pkg::TAG_U64;
         uint_nbytes = 4'd8;
      end
   end

   always_comb begin
      entry_valid = 1'b1;
      tag         = 8'd0;
      nbytes      = 4'd0;
      data        = value;
      case (mve_pkg::action_type'(action))
         mve_pkg::ACT_NIL:   tag = mve_pkg::TAG_NIL;
         mve_pkg::ACT_TRUE:  tag = mve_pkg::TAG_TRUE;
         mve_pkg::ACT_FALSE: tag = mve_pkg::TAG_FALSE;
         mve_pkg::ACT_SINT: begin
            if (!value[63]) begin
               tag    = uint_tag;
               nbytes = uint_nbytes;
            end else if (&value[63:5]) begin
               tag = value[7:0];
            end else if (&value[63:7]) begin
               tag    = mve_pkg::TAG_I8;
               nbytes = 4'd1;
            end else if (&value[63:15]) begin
               tag    = mve_pkg::TAG_I16;
               nbytes = 4'd2;
            end else if (&value[63:31]) begin
               tag    = mve_pkg::TAG_I32;
               nbytes = 4'd4;
            end else begin
               tag    = mve_pkg::TAG_I64;
               nbytes = 4'd8;
            end
         end
         mve_pkg::ACT_UINT: begin
            tag    = uint_tag;
            nbytes = uint_nbytes;
         end
         mve_pkg::ACT_F32: begin
            tag    = mve_pkg::TAG_F32;
            nbytes = 4'd4;
         end
         mve_pkg::ACT_F64: begin
            tag    = mve_pkg::TAG_F64;
            nbytes = 4'd8;
         end
         mve_pkg::ACT_STR: begin
            data = {32'd0, length};
            if (length[31:5] == 27'd0) begin
               tag = mve_pkg::TAG_FIXSTR | {3'd0, length[4:0]};
            end else if (length[31:8] == 24'd0) begin
               tag    = mve_pkg::TAG_STR8;
               nbytes = 4'd1;
            end else if (length[31:16] == 16'd0) begin
               tag    = mve_pkg::TAG_STR16;
               nbytes = 4'd2;
            end else begin
               tag    = mve_pkg::TAG_STR32;
               nbytes = 4'd4;
            end
         end
         mve_pkg::ACT_BIN: begin
            data = {32'd0, length};
            if (length[31:8] == 24'd0) begin
               tag    = mve_pkg::TAG_BIN8;
               nbytes = 4'd1;
            end else if (length[31:16] == 16'd0) begin
               tag    = mve_pkg::TAG_BIN16;
               nbytes = 4'd2;
            end else begin
               tag    = mve_pkg::TAG_BIN32;
               nbytes = 4'd4;
            end
         end
         mve_pkg::ACT_MAP: begin
            data = {32'd0, length};
            if (length[31:4] == 28'd0) begin
               tag = mve_pkg::TAG_FIXMAP | {4'd0, length[3:0]};
            end else if (length[31:16] == 16'd0) begin
               tag    = mve_pkg::TAG_MAP16;
               nbytes = 4'd2;
            end else begin
               tag    = mve_pkg::TAG_MAP32;
               nbytes = 4'd4;
            end
         end
         mve_pkg::ACT_ARRAY: begin
            data = {32'd0, length};
            if (length[31:4] == 28'd0) begin
               tag = mve_pkg::TAG_FIXARR | {4'd0, length[3:0]};
            end else if (length[31:16] == 16'd0) begin
               tag    = mve_pkg::TAG_ARR16;
               nbytes = 4'd2;
            end else begin
               tag    = mve_pkg::TAG_ARR32;
               nbytes = 4'd4;
            end
         end
         mve_pkg::ACT_PAYLOAD: tag = payload_byte;
         default: entry_valid = 1'b0;
      endcase
   end

   // move the data bytes up so they follow the tag, big-endian
   always_comb begin
      case (nbytes)
         4'd0:    aligned = 64'd0;
         4'd1:    aligned = {data[7:0], 56'd0};
         4'd2:    aligned = {data[15:0], 48'd0};
         4'd4:    aligned = {data[31:0], 32'd0};
         default: aligned = data;
      endcase
   end

   assign entry.bytes = {tag, aligned};
   assign entry.count = nbytes + 4'd1;

endmodule
`default_nettype wire

>>> src/mve_queue.sv
`default_nettype none
module mve_queue #(
   parameter int unsigned DEPTH = mve_pkg::QUEUE_DEPTH
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire mve_pkg::entry_type wr_entry,
   output logic                    full,
   input  wire logic               rd_en,
   output logic                    rd_valid,
   output mve_pkg::entry_type      rd_entry
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   mve_pkg::entry_type store_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_wr, do_rd;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_entry = store_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + 1'b1;
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         store_ff[wr_ptr_ff] <= wr_entry;
      end
   end

endmodule
`default_nettype wire

>>> src/mve_back.sv
`default_nettype none
module mve_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire mve_pkg::entry_type q_entry,
   output logic                    q_take,
   output logic [7:0]              out_byte,
   output logic                    out_last,
   output logic                    out_empty,
   input  wire logic               out_pop
);

   logic [mve_pkg::ITEM_W-1:0]  cur_bytes_ff, cur_bytes_in;
   logic [mve_pkg::COUNT_W-1:0] cur_count_ff, cur_count_in;
   logic                        cur_valid_ff, cur_valid_in;
   logic [7:0]                  byte_ff, byte_in;
   logic                        last_ff, last_in;
   logic                        out_valid_ff, out_valid_in;
   logic                        out_load, emit, cur_done;

   assign out_load = !out_valid_ff || out_pop;
   assign emit     = cur_valid_ff && out_load;
   assign cur_done = emit && (cur_count_ff == mve_pkg::COUNT_W'(1));
   // the next item moves in as soon as the current one sends its final byte
   assign q_take   = q_valid && (!cur_valid_ff || cur_done);

   always_comb begin
      cur_bytes_in = cur_bytes_ff;
      cur_count_in = cur_count_ff;
      cur_valid_in = cur_valid_ff;
      if (q_take) begin
         cur_bytes_in = q_entry.bytes;
         cur_count_in = q_entry.count;
         cur_valid_in = 1'b1;
      end else if (emit) begin
         cur_bytes_in = {cur_bytes_ff[mve_pkg::ITEM_W-9:0], 8'd0};
         cur_count_in = cur_count_ff - 1'b1;
         cur_valid_in = !cur_done;
      end
   end

   always_comb begin
      byte_in      = byte_ff;
      last_in      = last_ff;
      out_valid_in = out_valid_ff;
      if (emit) begin
         byte_in      = cur_bytes_ff[mve_pkg::ITEM_W-1 -: 8];
         last_in      = (cur_count_ff == mve_pkg::COUNT_W'(1));
         out_valid_in = 1'b1;
      end else if (out_load) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_bytes_ff <= cur_bytes_in;
      cur_count_ff <= cur_count_in;
      byte_ff      <= byte_in;
      last_ff      <= last_in;
   end

   assign out_byte  = byte_ff;
   assign out_last  = last_ff;
   assign out_empty = !out_valid_ff;

endmodule
`default_nettype wire

>>> src/msgpack_value_encoder_top.sv
// MessagePack value encoder.
// Input side is a queue write port: drive req_action/req_value/req_length/
// req_payload_byte with push; the word is taken at a clock edge with push
// high and full low. Unused action codes are taken and produce nothing.
// Output side is a queue read port: while empty is low, rsp_out_byte and
// rsp_last show the next encoded byte; pop takes it. Each input word gives
// 1 to 9 bytes, most significant first, with rsp_last on the final one.
// The first byte of a word is classified and written into the queue at the
// edge that takes it, then moves from the queue into the serializer, then
// from the serializer into the output register. Throughput: one output
// byte per cycle while pop is not held off, set by the single-byte
// serializer, so single-byte words (payload, fixint, nil) stream at one
// word per cycle and a word of n bytes occupies the back end until all
// n bytes are sent. The front keeps accepting into a QUEUE_DEPTH entry
// queue while the back end is busy; full rises when the queue fills.
// When the receiver holds off pop, the output byte holds, the serializer
// and queue fill and full then stalls the sender. Reset (synchronous)
// empties the queue, serializer and output register.
`default_nettype none
module msgpack_value_encoder_top #(
   parameter int unsigned QUEUE_DEPTH = mve_pkg::QUEUE_DEPTH
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic [3:0]  req_action,
   input  wire logic [63:0] req_value,
   input  wire logic [31:0] req_length,
   input  wire logic [7:0]  req_payload_byte,
   input  wire logic        push,
   output logic             full,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_last,
   output logic             empty,
   input  wire logic        pop
);

   mve_pkg::entry_type front_entry;
   mve_pkg::entry_type q_entry;
   logic               front_valid;
   logic               q_valid;
   logic               q_take;

   mve_front u_front (
      .action       (req_action),
      .value        (req_value),
      .length       (req_length),
      .payload_byte (req_payload_byte),
      .entry_valid  (front_valid),
      .entry        (front_entry)
   );

   mve_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (push && front_valid),
      .wr_entry (front_entry),
      .full     (full),
      .rd_en    (q_take),
      .rd_valid (q_valid),
      .rd_entry (q_entry)
   );

   mve_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_entry   (q_entry),
      .q_take    (q_take),
      .out_byte  (rsp_out_byte),
      .out_last  (rsp_last),
      .out_empty (empty),
      .out_pop   (pop)
   );

endmodule
`default_nettype wire

>>> src/mve_checker.sv
`default_nettype none
module mve_checker (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       push,
   input wire logic       full,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_last,
   input wire logic       empty,
   input wire logic       pop
);

   // nothing is left to show right after reset
   assert property (@(posedge clock) $past(reset) |-> empty)
      else $error("output not empty after reset");

   // a stalled word holds still
   assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_out_byte) && $stable(rsp_last)))
      else $error("stalled output word changed");

   // the rest of an item is already in the serializer, so no bubble inside it
   assert property (@(posedge clock) disable iff (reset)
      (!empty && pop && !rsp_last) |=> !empty)
      else $error("gap inside an encoded item");

   // the queue only fills because of a word taken on the previous edge
   assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("full rose without a push");

endmodule

bind msgpack_value_encoder_top mve_checker u_mve_checker (.*);
`default_nettype wire

>>> test/msgpack_value_encoder_top_test.sv
`timescale 1ns / 100ps
module msgpack_value_encoder_top_test;

   localparam logic [3:0] ACT_SPARE_FIRST = 4'd12;
   localparam logic [3:0] ACT_SPARE_LAST  = 4'd15;
   localparam int RANDOM_WORDS = 206;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [3:0]         act;
      logic [63:0]        value;
      logic [31:0]        len;
      logic [7:0]         pb;
      logic               typed;
      mve_pkg::entry_type golden;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } enc_byte_type;

   logic        clock;
   logic        reset = 1'b1;
   logic [3:0]  req_action = '0;
   logic [63:0] req_value = '0;
   logic [31:0] req_length = '0;
   logic [7:0]  req_payload_byte = '0;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic        full;
   logic [7:0]  rsp_out_byte;
   logic        rsp_last;
   logic        empty;

   stim_row_type       plan[$];
   stim_row_type       offered_words[$];
   enc_byte_type       pending_bytes[$];
   int                 error_count = 0;
   bit                 send_steady = 1'b0;
   bit                 take_steady = 1'b1;

   stim_row_type       accepted_word;
   mve_pkg::entry_type accepted_enc;
   enc_byte_type       want;
   int                 k;

   msgpack_value_encoder_top u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_action       (req_action),
      .req_value        (req_value),
      .req_length       (req_length),
      .req_payload_byte (req_payload_byte),
      .push             (push),
      .full             (full),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_last         (rsp_last),
      .empty            (empty),
      .pop              (pop)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------- encoding

   function automatic mve_pkg::entry_type lone_byte(input logic [7:0] b);
      mve_pkg::entry_type e;
      e.bytes = {b, 64'd0};
      e.count = 4'd1;
      return e;
   endfunction

   // tag then the low n bytes of v, big-endian
   function automatic mve_pkg::entry_type with_tag(input logic [7:0] tag,
                                                   input logic [63:0] v, input int n);
      mve_pkg::entry_type e;
      e.bytes = {tag, v << (64 - 8 * n)};
      e.count = 4'(n + 1);
      return e;
   endfunction

   function automatic mve_pkg::entry_type encode_uint(input logic [63:0] v);
      if (v < 64'd128)
         return lone_byte(v[7:0]);
      else if (v < 64'd256)
         return with_tag(mve_pkg::TAG_U8, v, 1);
      else if (v < 64'd65536)
         return with_tag(mve_pkg::TAG_U16, v, 2);
      else if (v < 64'h1_0000_0000)
         return with_tag(mve_pkg::TAG_U32, v, 4);
      else
         return with_tag(mve_pkg::TAG_U64, v, 8);
   endfunction

   function automatic mve_pkg::entry_type encode_sint(input logic [63:0] v);
      logic signed [63:0] s;
      s = v;
      if (s < -64'sd32) begin
         if (s < -64'sd2147483648)
            return with_tag(mve_pkg::TAG_I64, v, 8);
         else if (s < -64'sd32768)
            return with_tag(mve_pkg::TAG_I32, v, 4);
         else if (s < -64'sd128)
            return with_tag(mve_pkg::TAG_I16, v, 2);
         else
            return with_tag(mve_pkg::TAG_I8, v, 1);
      end else if (s < 64'sd128) begin
         return lone_byte(v[7:0]);
      end
      return encode_uint(v);
   endfunction

   // fix_limit of zero means the header has no fix form
   function automatic mve_pkg::entry_type encode_header(input logic [31:0] len,
                                               input logic [7:0] fix_tag, input int fix_limit,
                                               input bit has8, input logic [7:0] tag8,
                                               input logic [7:0] tag16, input logic [7:0] tag32);
      logic [63:0] l;
      l = {32'd0, len};
      if (fix_limit != 0 && l < 64'(fix_limit))
         return lone_byte(fix_tag | len[7:0]);
      else if (has8 && l < 64'd256)
         return with_tag(tag8, l, 1);
      else if (l < 64'd65536)
         return with_tag(tag16, l, 2);
      return with_tag(tag32, l, 4);
   endfunction

   function automatic mve_pkg::entry_type encode_value(input logic [3:0] act,
                                                       input logic [63:0] v,
                                                       input logic [31:0] len,
                                                       input logic [7:0] pb);
      mve_pkg::entry_type e;
      e = '0;
      case (act)
         mve_pkg::ACT_NIL:     e = lone_byte(mve_pkg::TAG_NIL);
         mve_pkg::ACT_TRUE:    e = lone_byte(mve_pkg::TAG_TRUE);
         mve_pkg::ACT_FALSE:   e = lone_byte(mve_pkg::TAG_FALSE);
         mve_pkg::ACT_SINT:    e = encode_sint(v);
         mve_pkg::ACT_UINT:    e = encode_uint(v);
         mve_pkg::ACT_F32:     e = with_tag(mve_pkg::TAG_F32, {32'd0, v[31:0]}, 4);
         mve_pkg::ACT_F64:     e = with_tag(mve_pkg::TAG_F64, v, 8);
         mve_pkg::ACT_STR:     e = encode_header(len, mve_pkg::TAG_FIXSTR, 32, 1'b1,
                                                 mve_pkg::TAG_STR8, mve_pkg::TAG_STR16,
                                                 mve_pkg::TAG_STR32);
         mve_pkg::ACT_BIN:     e = encode_header(len, 8'h00, 0, 1'b1, mve_pkg::TAG_BIN8,
                                                 mve_pkg::TAG_BIN16, mve_pkg::TAG_BIN32);
         mve_pkg::ACT_MAP:     e = encode_header(len, mve_pkg::TAG_FIXMAP, 16, 1'b0, 8'h00,
                                                 mve_pkg::TAG_MAP16, mve_pkg::TAG_MAP32);
         mve_pkg::ACT_ARRAY:   e = encode_header(len, mve_pkg::TAG_FIXARR, 16, 1'b0, 8'h00,
                                                 mve_pkg::TAG_ARR16, mve_pkg::TAG_ARR32);
         mve_pkg::ACT_PAYLOAD: e = lone_byte(pb);
         default:              e = '0;
      endcase
      return e;
   endfunction

   // ---------------------------------------------------------------- stimulus

   function automatic stim_row_type row(input logic [3:0] act, input logic [63:0] v,
                                        input logic [31:0] len, input logic [7:0] pb);
      stim_row_type r;
      r.act    = act;
      r.value  = v;
      r.len    = len;
      r.pb     = pb;
      r.typed  = 1'b0;
      r.golden = '0;
      return r;
   endfunction

   function automatic stim_row_type row_typed(input logic [3:0] act, input logic [63:0] v,
                                              input logic [31:0] len, input logic [7:0] pb,
                                              input logic [3:0] n, input logic [71:0] b);
      stim_row_type r;
      r              = row(act, v, len, pb);
      r.typed        = 1'b1;
      r.golden.bytes = b;
      r.golden.count = n;
      return r;
   endfunction

   function automatic stim_row_type random_word();
      stim_row_type r;
      int sel;
      sel = $urandom_range(0, 19);
      if (sel == 0)
         r.act = 4'($urandom_range(ACT_SPARE_FIRST, ACT_SPARE_LAST));
      else if (sel < 8)
         r.act = mve_pkg::ACT_PAYLOAD;
      else
         r.act = 4'($urandom_range(mve_pkg::ACT_NIL, mve_pkg::ACT_ARRAY));
      // spread magnitudes so every integer and header form is reached
      r.value = {$urandom, $urandom} >> $urandom_range(0, 63);
      if ($urandom_range(0, 1) == 1)
         r.value = ~r.value;
      r.len    = $urandom >> $urandom_range(0, 31);
      r.pb     = 8'($urandom_range(0, 255));
      r.typed  = 1'b0;
      r.golden = '0;
      return r;
   endfunction

   task automatic send_word(input stim_row_type r);
      int gap;
      if ($urandom_range(0, 15) == 0)
         send_steady = !send_steady;
      gap = send_steady ? 0 : $urandom_range(0, 10);
      if (gap != 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      offered_words.push_back(r);
      req_action       <= r.act;
      req_value        <= r.value;
      req_length       <= r.len;
      req_payload_byte <= r.pb;
      push             <= 1'b1;
      do @(posedge clock); while (full);
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      if (!reset) begin
         if (pop && !empty) begin
            if (pending_bytes.size() == 0) begin
               error_count++;
               $display("%0t: unexpected word: expected none, actual byte %h last %b",
                        $realtime, rsp_out_byte, rsp_last);
            end else begin
               want = pending_bytes.pop_front();
               if (rsp_out_byte !== want.data) begin
                  error_count++;
                  $display("%0t: out_byte mismatch: expected %h, actual %h",
                           $realtime, want.data, rsp_out_byte);
               end
               if (rsp_last !== want.last) begin
                  error_count++;
                  $display("%0t: last mismatch: expected %b, actual %b",
                           $realtime, want.last, rsp_last);
               end
            end
         end
         if (push && !full) begin
            accepted_word = offered_words.pop_front();
            if (accepted_word.typed)
               accepted_enc = accepted_word.golden;
            else
               accepted_enc = encode_value(accepted_word.act, accepted_word.value,
                                           accepted_word.len, accepted_word.pb);
            for (k = 0; k < accepted_enc.count; k++)
               pending_bytes.push_back({accepted_enc.bytes[mve_pkg::ITEM_W-1-8*k -: 8],
                                        k == accepted_enc.count - 1});
         end
      end
   end

   // receiver: random pops, plus long hold-offs so the queue backs up into full
   initial begin
      int gap;
      int bytes_taken;
      bytes_taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if ($urandom_range(0, 15) == 0)
            take_steady = !take_steady;
         gap = take_steady ? 0 : $urandom_range(0, 10);
         if (bytes_taken == 60 || bytes_taken == 300)
            gap = HOLD_CYCLES;
         if (gap != 0) begin
            pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         pop <= 1'b1;
         do @(posedge clock); while (empty);
         bytes_taken++;
      end
   end

   initial begin
      int i;
      plan.push_back(row_typed(mve_pkg::ACT_NIL, '1, '1, '1, 4'd1,
                               {mve_pkg::TAG_NIL, 64'd0}));
      plan.push_back(row_typed(mve_pkg::ACT_TRUE, '0, '0, '0, 4'd1,
                               {mve_pkg::TAG_TRUE, 64'd0}));
      plan.push_back(row_typed(mve_pkg::ACT_FALSE, '1, '1, '1, 4'd1,
                               {mve_pkg::TAG_FALSE, 64'd0}));
      plan.push_back(row_typed(mve_pkg::ACT_SINT, 64'hFFFF_FFFF_FFFF_FFFF, '0, '0, 4'd1,
                               {8'hFF, 64'd0}));
      plan.push_back(row(mve_pkg::ACT_SINT, -64'sd33, '0, '0));
      plan.push_back(row(mve_pkg::ACT_SINT, -64'sd32769, '0, '0));
      plan.push_back(row(mve_pkg::ACT_SINT, -64'sd2147483649, '0, '0));
      plan.push_back(row_typed(mve_pkg::ACT_SINT, 64'h8000_0000_0000_0000, '0, '0, 4'd9,
                               {mve_pkg::TAG_I64, 64'h8000_0000_0000_0000}));
      plan.push_back(row_typed(mve_pkg::ACT_SINT, 64'h7FFF_FFFF_FFFF_FFFF, '0, '0, 4'd9,
                               {mve_pkg::TAG_U64, 64'h7FFF_FFFF_FFFF_FFFF}));
      plan.push_back(row(mve_pkg::ACT_SINT, 64'd200, '0, '0));
      plan.push_back(row_typed(mve_pkg::ACT_UINT, 64'd127, '0, '0, 4'd1, {8'h7F, 64'd0}));
      plan.push_back(row(mve_pkg::ACT_UINT, 64'd128, '0, '0));
      plan.push_back(row(mve_pkg::ACT_UINT, 64'd65536, '0, '0));
      plan.push_back(row_typed(mve_pkg::ACT_UINT, '1, '0, '0, 4'd9,
                               {mve_pkg::TAG_U64, 64'hFFFF_FFFF_FFFF_FFFF}));
      // upper half of value must not reach the f32 encoding
      plan.push_back(row(mve_pkg::ACT_F32, 64'hDEAD_BEEF_3F80_0000, '1, '1));
      plan.push_back(row(mve_pkg::ACT_F64, 64'h4009_21FB_5444_2D18, '0, '0));
      plan.push_back(row_typed(mve_pkg::ACT_STR, '0, 32'd31, '0, 4'd1,
                               {mve_pkg::TAG_FIXSTR | 8'd31, 64'd0}));
      plan.push_back(row(mve_pkg::ACT_STR, '0, 32'd32, '0));
      plan.push_back(row_typed(mve_pkg::ACT_BIN, '1, 32'd0, '1, 4'd2,
                               {mve_pkg::TAG_BIN8, 8'h00, 56'd0}));
      plan.push_back(row_typed(mve_pkg::ACT_MAP, '0, 32'd15, '0, 4'd1,
                               {mve_pkg::TAG_FIXMAP | 8'd15, 64'd0}));
      plan.push_back(row(mve_pkg::ACT_MAP, '0, 32'd65535, '0));
      plan.push_back(row_typed(mve_pkg::ACT_ARRAY, '0, 32'hFFFF_FFFF, '0, 4'd5,
                               {mve_pkg::TAG_ARR32, 32'hFFFF_FFFF, 32'd0}));
      plan.push_back(row_typed(mve_pkg::ACT_PAYLOAD, '1, '1, 8'hFF, 4'd1, {8'hFF, 64'd0}));
      plan.push_back(row_typed(mve_pkg::ACT_PAYLOAD, '0, '0, 8'h00, 4'd1, {8'h00, 64'd0}));
      // spare action codes are taken and give no word
      plan.push_back(row_typed(ACT_SPARE_FIRST, '1, '1, '1, 4'd0, 72'd0));
      plan.push_back(row_typed(ACT_SPARE_LAST, '0, '0, '0, 4'd0, 72'd0));

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (i = 0; i < plan.size(); i++)
         send_word(plan[i]);
      for (i = 0; i < RANDOM_WORDS; i++)
         send_word(random_word());
      push <= 1'b0;

      while (pending_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0)
         $display("msgpack_value_encoder_top verification clean");
      else
         $display("msgpack_value_encoder_top verification failed");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("msgpack_value_encoder_top verification failed");
      $finish;
   end

endmodule
